// ===== sv/rms_pkg.sv =====
// Shared constants and types for the running mean and standard deviation core.
package rms_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int MAX_COUNT = 65536;
    localparam int CNT_W     = 17;
    localparam int SUM_W     = 33;
    localparam int SQ_W      = 48;
    localparam int PROD_W    = 64;
    localparam int DSR_W     = 34;
    localparam int FRAC_W    = 8;
    localparam int VAR_FRAC  = 16;
    localparam int DVD_W     = PROD_W + VAR_FRAC;
    localparam int MEAN_W    = 24;
    localparam int SD_W      = 24;

    localparam int DIV_STEPS  = DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int SQRT_STEPS = PROD_W / 2;
    localparam int STEP_W     = $clog2(SUM_W + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [MEAN_W-1:0] MEAN_POS_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0] MEAN_NEG_MAG = {1'b1, {(MEAN_W-1){1'b0}}};
    localparam logic [SD_W-1:0]   SD_MAX       = {SD_W{1'b1}};

    // Accumulator contents of one finished set.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [CNT_W-1:0] n;
        logic             sat;
    } snap_t;

    typedef struct packed {
        logic  valid;
        snap_t snap;
    } push_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MULN,
        BK_MULS,
        BK_DIVM_GO,
        BK_DIVM,
        BK_DIVV_GO,
        BK_DIVV,
        BK_SQRT,
        BK_DONE
    } back_state_t;

endpackage

// ===== sv/rms_in_if.sv =====
// Sample channel: valid/ready handshake with a signed sample and an end-of-set flag.
interface rms_in_if
    import rms_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

// ===== sv/rms_out_if.sv =====
// Result channel: valid/ready handshake with the statistics of one finished set.
interface rms_out_if
    import rms_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] mean_value;
    logic [SD_W-1:0]          std_dev;
    logic [CNT_W-1:0]         sample_count;
    logic                     overflowed;

    modport source (output valid, output mean_value, output std_dev, output sample_count,
                    output overflowed, input ready);
    modport sink (input valid, input mean_value, input std_dev, input sample_count,
                  input overflowed, output ready);
endinterface

// ===== sv/rms_front.sv =====
// Front end: accumulates sum, sum of squares and count, and hands finished sets to the queue.
module rms_front
    import rms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rms_in_if.sink      samples,
    output push_t       push,
    input  logic        q_full
);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sat_reg, sat_next;

    logic                         accept;
    logic                         at_max;
    logic signed [2*SAMPLE_W-1:0] square;
    logic [SUM_W-1:0]             sum_acc;
    logic [SQ_W-1:0]              sq_acc;
    logic [CNT_W-1:0]             cnt_acc;

    assign samples.ready = !q_full;
    assign accept        = samples.valid && samples.ready;
    assign at_max        = cnt_reg >= CNT_W'(MAX_COUNT);
    assign square        = samples.sample * samples.sample;

    always_comb
    begin
        // Once the set is full, further samples only mark saturation.
        if (at_max)
        begin
            sum_acc = sum_reg;
            sq_acc  = sq_reg;
            cnt_acc = cnt_reg;
        end
        else
        begin
            sum_acc = sum_reg + {{(SUM_W-SAMPLE_W){samples.sample[SAMPLE_W-1]}},
                                 samples.sample};
            sq_acc  = sq_reg + {{(SQ_W-2*SAMPLE_W){1'b0}}, square};
            cnt_acc = cnt_reg + CNT_W'(1);
        end

        sum_next        = sum_reg;
        sq_next         = sq_reg;
        cnt_next        = cnt_reg;
        sat_next        = sat_reg;
        push.valid      = 1'b0;
        push.snap.sum   = sum_acc;
        push.snap.sq    = sq_acc;
        push.snap.n     = cnt_acc;
        push.snap.sat   = sat_reg | at_max;

        if (accept)
        begin
            if (samples.last)
            begin
                push.valid = 1'b1;
                sum_next   = '0;
                sq_next    = '0;
                cnt_next   = '0;
                sat_next   = 1'b0;
            end
            else
            begin
                sum_next = sum_acc;
                sq_next  = sq_acc;
                cnt_next = cnt_acc;
                sat_next = sat_reg | at_max;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sq_reg  <= '0;
            cnt_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
            cnt_reg <= cnt_next;
            sat_reg <= sat_next;
        end
    end

endmodule

// ===== sv/rms_queue.sv =====
// Short queue of finished-set snapshots between the front end and the back end.
module rms_queue
    import rms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output snap_t head
);

    snap_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign full    = fill_reg == (QPTR_W+1)'(QDEPTH);
    assign empty   = fill_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.snap;
        end
    end

endmodule

// ===== sv/rms_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module rms_div
    import rms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DSR_W-1:0]     dsr_reg, dsr_next;
    logic [DSR_W-1:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]    quot_reg, quot_next;

    logic [DSR_W:0] shifted;
    logic [DSR_W:0] diff;
    logic           fits;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            // The remainder stays below the divisor, so one compare settles each bit.
            rem_next  = fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            quot_next = {quot_reg[PROD_W-2:0], fits};
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = cnt_reg == DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ===== sv/rms_back.sv =====
// Back end: sequences products, both divisions and the square root, and holds the result.
module rms_back
    import rms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  snap_t     q_head,
    output logic      pop,
    output div_req_t  div_req,
    input  div_rsp_t  div_rsp,
    rms_out_if.source results
);

    back_state_t       state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    logic              sneg_reg, sneg_next;
    logic [SUM_W-1:0]  smag_reg, smag_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              sat_reg, sat_next;
    logic [PROD_W-1:0] acc_a_reg, acc_a_next;
    logic [PROD_W-1:0] acc_b_reg, acc_b_next;
    logic [DSR_W-1:0]  acc_d_reg, acc_d_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [DSR_W-1:0]  mcand_d_reg, mcand_d_next;
    logic [SUM_W-1:0]  mplier_reg, mplier_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic [PROD_W-1:0] x_reg, x_next;
    logic [PROD_W-1:0] r_reg, r_next;
    logic [PROD_W-1:0] b_reg, b_next;
    logic [MEAN_W-1:0] out_mean_reg, out_mean_next;
    logic [SD_W-1:0]   out_sd_reg, out_sd_next;
    logic [CNT_W-1:0]  out_n_reg, out_n_next;
    logic              out_ovf_reg, out_ovf_next;

    logic [PROD_W-1:0] rb;
    logic [PROD_W-1:0] num;
    logic [PROD_W-1:0] quot;
    logic [MEAN_W-1:0] mq;

    assign rb   = r_reg + b_reg;
    assign num  = (acc_a_reg > acc_b_reg) ? acc_a_reg - acc_b_reg : '0;
    assign quot = div_rsp.quotient;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !results.ready;
        sneg_next      = sneg_reg;
        smag_next      = smag_reg;
        n_next         = n_reg;
        sat_next       = sat_reg;
        acc_a_next     = acc_a_reg;
        acc_b_next     = acc_b_reg;
        acc_d_next     = acc_d_reg;
        mcand_next     = mcand_reg;
        mcand_d_next   = mcand_d_reg;
        mplier_next    = mplier_reg;
        mean_next      = mean_reg;
        x_next         = x_reg;
        r_next         = r_reg;
        b_next         = b_reg;
        out_mean_next  = out_mean_reg;
        out_sd_next    = out_sd_reg;
        out_n_next     = out_n_reg;
        out_ovf_next   = out_ovf_reg;
        pop            = 1'b0;
        div_req        = '0;
        mq             = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop          = 1'b1;
                    sneg_next    = q_head.sum[SUM_W-1];
                    smag_next    = q_head.sum[SUM_W-1] ? -q_head.sum : q_head.sum;
                    n_next       = q_head.n;
                    sat_next     = q_head.sat;
                    acc_a_next   = '0;
                    acc_d_next   = '0;
                    mcand_next   = PROD_W'(q_head.sq);
                    mcand_d_next = DSR_W'(q_head.n);
                    mplier_next  = SUM_W'(q_head.n);
                    cnt_next     = STEP_W'(CNT_W);
                    state_next   = BK_MULN;
                end
            end

            BK_MULN:
            begin
                // n times the square sum and n squared share the multiplier bits of n.
                if (mplier_reg[0])
                begin
                    acc_a_next = acc_a_reg + mcand_reg;
                    acc_d_next = acc_d_reg + mcand_d_reg;
                end
                mcand_next   = {mcand_reg[PROD_W-2:0], 1'b0};
                mcand_d_next = {mcand_d_reg[DSR_W-2:0], 1'b0};
                mplier_next  = {1'b0, mplier_reg[SUM_W-1:1]};
                cnt_next     = cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    mcand_next  = PROD_W'(smag_reg);
                    mplier_next = smag_reg;
                    acc_b_next  = '0;
                    cnt_next    = STEP_W'(SUM_W);
                    state_next  = BK_MULS;
                end
            end

            BK_MULS:
            begin
                if (mplier_reg[0])
                begin
                    acc_b_next = acc_b_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[SUM_W-1:1]};
                cnt_next    = cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    state_next = BK_DIVM_GO;
                end
            end

            BK_DIVM_GO:
            begin
                // Half the count is added first so the quotient rounds half away from zero.
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'({smag_reg, {FRAC_W{1'b0}}})
                                 + DVD_W'(n_reg[CNT_W-1:1]);
                div_req.divisor  = DSR_W'(n_reg);
                state_next       = BK_DIVM;
            end

            BK_DIVM:
            begin
                if (div_rsp.done)
                begin
                    if (sneg_reg)
                    begin
                        mq        = (quot > PROD_W'(MEAN_NEG_MAG)) ? MEAN_NEG_MAG
                                                                   : quot[MEAN_W-1:0];
                        mean_next = -mq;
                    end
                    else
                    begin
                        mean_next = (quot > PROD_W'(MEAN_POS_MAX)) ? MEAN_POS_MAX
                                                                   : quot[MEAN_W-1:0];
                    end
                    state_next = BK_DIVV_GO;
                end
            end

            BK_DIVV_GO:
            begin
                // Variance in Q16: (n * sum_sq - sum^2) * 2^16 / n^2, negative clamped to zero.
                div_req.start    = 1'b1;
                div_req.dividend = {num, {VAR_FRAC{1'b0}}};
                div_req.divisor  = acc_d_reg;
                state_next       = BK_DIVV;
            end

            BK_DIVV:
            begin
                if (div_rsp.done)
                begin
                    x_next     = quot;
                    r_next     = '0;
                    b_next     = {2'b01, {(PROD_W-2){1'b0}}};
                    cnt_next   = STEP_W'(SQRT_STEPS);
                    state_next = BK_SQRT;
                end
            end

            BK_SQRT:
            begin
                if (x_reg >= rb)
                begin
                    x_next = x_reg - rb;
                    r_next = {1'b0, r_reg[PROD_W-1:1]} + b_reg;
                end
                else
                begin
                    r_next = {1'b0, r_reg[PROD_W-1:1]};
                end
                b_next   = {2'b00, b_reg[PROD_W-1:2]};
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    state_next = BK_DONE;
                end
            end

            BK_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = mean_reg;
                    out_sd_next    = (r_reg > PROD_W'(SD_MAX)) ? SD_MAX : r_reg[SD_W-1:0];
                    out_n_next     = n_reg;
                    out_ovf_next   = sat_reg;
                    state_next     = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sneg_reg     <= sneg_next;
        smag_reg     <= smag_next;
        n_reg        <= n_next;
        sat_reg      <= sat_next;
        acc_a_reg    <= acc_a_next;
        acc_b_reg    <= acc_b_next;
        acc_d_reg    <= acc_d_next;
        mcand_reg    <= mcand_next;
        mcand_d_reg  <= mcand_d_next;
        mplier_reg   <= mplier_next;
        mean_reg     <= mean_next;
        x_reg        <= x_next;
        r_reg        <= r_next;
        b_reg        <= b_next;
        out_mean_reg <= out_mean_next;
        out_sd_reg   <= out_sd_next;
        out_n_reg    <= out_n_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.mean_value   = out_mean_reg;
    assign results.std_dev      = out_sd_reg;
    assign results.sample_count = out_n_reg;
    assign results.overflowed   = out_ovf_reg;

endmodule

// ===== sv/running_mean_stddev_core.sv =====
// Top level of the running mean and population standard deviation core.
// Samples are taken one per cycle while the four-entry set queue has room.
// The back end works on one set at a time, through 17+33 shift-add product steps, two 80-step
// divisions and 32 square-root steps. Reset is asynchronous and clears the accumulators, the
// queue and the output valid flag.
module running_mean_stddev_core
    import rms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rms_in_if.sink    samples,
    rms_out_if.source results
);

    // The front end folds every accepted sample transaction into the running sums.
    // On the sample that ends a set it pushes the final sums, the count and the
    // saturation flag into the queue and clears its accumulators, so the next set
    // can start in the following cycle without waiting for the slow arithmetic.
    push_t    push;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    snap_t    q_head;
    div_req_t div_req;
    div_rsp_t div_rsp;

    rms_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .push    (push),
        .q_full  (q_full)
    );

    // The queue decouples the two halves: the front end stalls only when four
    // finished sets are already waiting for the back end.
    rms_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    // One restoring divider serves both the mean and the variance division.
    rms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The back end forms n*sum_sq, n^2 and sum^2 by shift-and-add, then the
    // rounded mean, the Q16 variance and its integer square root. The result
    // sits in an output register, so the back end can start the next set while
    // the result transaction is still waiting to be taken.
    rms_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .results (results)
    );

endmodule

// ===== sv/rms_checker.sv =====
// Port-level checks for the running mean and standard deviation core, bound to the top level.
module rms_checker
    import rms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [MEAN_W-1:0] out_mean,
    input logic [SD_W-1:0]   out_sd,
    input logic [CNT_W-1:0]  out_count,
    input logic              out_ovf
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_mean) && $stable(out_sd)
                                    && $stable(out_count) && $stable(out_ovf))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count != '0 && out_count <= CNT_W'(MAX_COUNT))
        else $error("sample count out of range");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ovf |-> out_count == CNT_W'(MAX_COUNT))
        else $error("overflow flagged on a set that is not full");

    a_single_zero_sd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_count == CNT_W'(1) |-> out_sd == '0)
        else $error("nonzero deviation for a single-sample set");

endmodule

bind running_mean_stddev_core rms_checker u_rms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_mean  (results.mean_value),
    .out_sd    (results.std_dev),
    .out_count (results.sample_count),
    .out_ovf   (results.overflowed)
);

// ===== tb/tb_running_mean_stddev_core.sv =====
// Self-checking testbench for the running mean and standard deviation core.
module tb_running_mean_stddev_core;
    import rms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One sample transaction waiting to be driven, with its pacing attributes.
    // gap:   idle cycles the sender inserts before this sample.
    // drain: the sender holds this sample until every pending result is back.
    // calm:  no idling on either side while this sample's set is in flight.
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        int unsigned                gap;
        bit                         drain;
        bit                         calm;
    } sample_item_t;

    // Statistics of one finished set, laid out like the result channel.
    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_value;
        logic [SD_W-1:0]          std_dev;
        logic [CNT_W-1:0]         sample_count;
        logic                     overflowed;
    } set_stats_t;

    // Value distributions used to build random sets.
    typedef enum int {
        SPREAD_FULL,
        SPREAD_TIGHT,
        SPREAD_RAILS,
        SPREAD_FLAT,
        SPREAD_NEAR
    } spread_t;

    localparam int MAX_IDLE   = 13;
    localparam int RAND_ITEMS = 500;
    localparam int TAIL_WAIT  = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Local copies of everything the testbench drives, so that all block inputs
    // hold a known value from time zero.
    logic                       tx_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0] tx_sample = '0;
    logic                       tx_last   = 1'b0;
    logic                       rx_ready  = 1'b0;

    rms_in_if  in_ch ();
    rms_out_if out_ch ();

    assign in_ch.valid  = tx_valid;
    assign in_ch.sample = tx_sample;
    assign in_ch.last   = tx_last;
    assign out_ch.ready = rx_ready;

    running_mean_stddev_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_ch),
        .results (out_ch)
    );

    // Stimulus waiting to be driven, and statistics waiting to come back.
    sample_item_t pending_samples[$];
    set_stats_t   expected_stats[$];

    // Accumulator image of the block, updated on every accepted sample.
    logic [SUM_W-1:0] acc_sum = '0;
    logic [SQ_W-1:0]  acc_sq  = '0;
    longint unsigned  acc_n   = 0;
    bit               acc_sat = 1'b0;

    logic        in_fire  = 1'b0;
    logic        out_fire = 1'b0;
    int unsigned gap_wait = 0;
    int unsigned rx_stall = 0;
    bit          rx_calm  = 1'b0;

    int unsigned errors        = 0;
    int unsigned samples_sent  = 0;
    int unsigned sets_checked  = 0;
    int unsigned sets_overflow = 0;

    // Integer square root by the classic bit-pair method, floor of sqrt(x).
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = x;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Folds one sample into the accumulator image. On the last sample of a set it
    // produces the mean and population standard deviation and clears the image.
    // The variance is formed exactly as (n*sum_sq - sum^2) / n^2 in Q16, clamped at
    // zero, and its square root gives the Q8 standard deviation.
    function automatic void accumulate_stats(input logic signed [SAMPLE_W-1:0] s,
                                             input logic lst,
                                             output bit emit,
                                             output set_stats_t res);
        longint signed   sval;
        longint unsigned mag;
        longint unsigned n;
        longint unsigned smag;
        longint unsigned mq;
        longint unsigned mneg;
        longint unsigned prod_a;
        longint unsigned prod_b;
        longint unsigned num;
        longint unsigned den;
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned var_q16;
        longint unsigned sd;
        logic [SUM_W-1:0] sum_neg;
        bit              sneg;

        sval = s;
        mag  = (sval < 0) ? -sval : sval;
        emit = 1'b0;
        res  = '0;

        // Once the set is full, further samples only mark the set as saturated.
        if (acc_n >= MAX_COUNT)
        begin
            acc_sat = 1'b1;
        end
        else
        begin
            acc_sum = acc_sum + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
            acc_sq  = acc_sq + SQ_W'(mag * mag);
            acc_n   = acc_n + 1;
        end

        if (lst)
        begin
            n       = acc_n;
            sneg    = acc_sum[SUM_W-1];
            sum_neg = -acc_sum;
            smag    = 64'(sneg ? sum_neg : acc_sum);

            // Mean in Q8, rounded half away from zero, then saturated.
            mq = (smag * 256 + n / 2) / n;
            if (sneg)
            begin
                if (mq > 64'd8388608)
                    mq = 64'd8388608;
                mneg = -mq;
                res.mean_value = mneg[MEAN_W-1:0];
            end
            else
            begin
                if (mq > 64'd8388607)
                    mq = 64'd8388607;
                res.mean_value = mq[MEAN_W-1:0];
            end

            prod_a  = n * acc_sq;
            prod_b  = smag * smag;
            num     = (prod_a > prod_b) ? (prod_a - prod_b) : 0;
            den     = n * n;
            quo     = num / den;
            rem     = num % den;
            var_q16 = quo * 65536 + (rem * 65536) / den;
            sd      = int_sqrt(var_q16);
            if (sd > SD_MAX)
                sd = 64'(SD_MAX);

            res.std_dev      = sd[SD_W-1:0];
            res.sample_count = n[CNT_W-1:0];
            res.overflowed   = acc_sat;
            emit             = 1'b1;

            acc_sum = '0;
            acc_sq  = '0;
            acc_n   = 0;
            acc_sat = 1'b0;
        end
    endfunction

    // Draws a sample value of the given distribution around a base value.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input spread_t spread,
                                                               input int base);
        int v;
        case (spread)
            SPREAD_TIGHT: v = base + int'($urandom_range(0, 16)) - 8;
            SPREAD_RAILS: v = $urandom_range(0, 1) ? 32767 : -32768;
            SPREAD_FLAT:  v = base;
            SPREAD_NEAR:  v = base + int'($urandom_range(0, 512)) - 256;
            default:      v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst,
                                input int unsigned gap, input bit drain, input bit calm);
        sample_item_t item;
        item.sample = s;
        item.last   = lst;
        item.gap    = gap;
        item.drain  = drain;
        item.calm   = calm;
        pending_samples.push_back(item);
    endtask

    // Free-running clock, 4 ns period.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Safety net: a correct run finishes well inside this time, even with every set
    // of a single sample, the longest idle gaps and every result stalled as long as
    // possible.
    initial
    begin
        #4_000_000;
        $display("running_mean_stddev_core: mismatch");
        $finish;
    end

    // Input side, rising edge: every accepted sample transaction is run through the
    // accumulator image, and a finished set leaves its statistics in the queue.
    always @(posedge clk)
    begin : sample_capture
        bit         emit;
        set_stats_t res;
        in_fire = rst_n && in_ch.valid && in_ch.ready;
        if (in_fire)
        begin
            accumulate_stats(in_ch.sample, in_ch.last, emit, res);
            if (emit)
                expected_stats.push_back(res);
            samples_sent++;
        end
    end

    // Sample driver, falling edge. A presented sample stays put until it has been
    // taken. Otherwise the next pending sample goes out once its idle gap has passed,
    // and a sample marked for draining waits until every result is back. The valid
    // line gets a single assignment per edge so a back-to-back sample never glitches.
    always @(negedge clk)
    begin : sample_driver
        logic next_valid;
        if (rst_n && !(tx_valid && !in_fire))
        begin
            next_valid = 1'b0;
            if (pending_samples.size() != 0)
            begin
                if (pending_samples[0].drain && expected_stats.size() != 0)
                begin
                    // Hold off until the block has delivered everything.
                end
                else if (gap_wait < pending_samples[0].gap)
                begin
                    gap_wait++;
                end
                else
                begin
                    tx_sample  <= pending_samples[0].sample;
                    tx_last    <= pending_samples[0].last;
                    rx_calm    <= pending_samples[0].calm;
                    pending_samples.pop_front();
                    next_valid = 1'b1;
                    gap_wait   = 0;
                end
            end
            tx_valid <= next_valid;
        end
    end

    // Result monitor, rising edge: each accepted result transaction is compared
    // with the oldest expected set statistics.
    always @(posedge clk)
    begin : result_monitor
        set_stats_t got;
        set_stats_t want;
        out_fire = rst_n && out_ch.valid && out_ch.ready;
        if (out_fire)
        begin
            got.mean_value   = out_ch.mean_value;
            got.std_dev      = out_ch.std_dev;
            got.sample_count = out_ch.sample_count;
            got.overflowed   = out_ch.overflowed;
            if (expected_stats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result mean=%0d sd=%0d n=%0d ovf=%0d",
                         $time, got.mean_value, got.std_dev, got.sample_count,
                         got.overflowed);
            end
            else
            begin
                want = expected_stats.pop_front();
                sets_checked++;
                if (want.overflowed)
                    sets_overflow++;
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mean/sd/n/ovf expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                             $time, want.mean_value, want.std_dev, want.sample_count,
                             want.overflowed, got.mean_value, got.std_dev,
                             got.sample_count, got.overflowed);
                end
            end
        end
    end

    // Result back-pressure, falling edge: after each accepted result the receiver
    // draws a fresh stall length; during calm stretches it never stalls.
    always @(negedge clk)
    begin : result_pacing
        if (rst_n)
        begin
            if (out_fire)
                rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
            else if (rx_stall != 0)
                rx_stall--;
            rx_ready <= (rx_stall == 0);
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        int      dir_vals [22] = '{32767, -32768, 0, 32767, -32768, 1, 2, -1, -2,
                                   -32768, -32768, -32768, -32768, 1, 0, 0,
                                   -32768, 32767, -32768, 32767, 0, 0};
        bit      dir_last [22] = '{1, 1, 1, 0, 1, 0, 1, 0, 1, 0, 0, 0, 1, 0, 0, 1,
                                   0, 0, 0, 0, 0, 1};
        int      items_made;
        int      len;
        int      base;
        int      k;
        int      pick;
        bit      calm;
        bit      drain;
        spread_t spread;
        logic signed [SAMPLE_W-1:0] s;

        // Directed sets: single samples at both rails and zero, a set with a
        // negative half-integer mean and the widest possible deviation, positive
        // and negative half-integer means, a set pinned at the negative rail (the
        // most negative mean, zero deviation), a non-terminating fraction, and a
        // mixed rail set.
        for (k = 0; k < 22; k++)
        begin
            s = SAMPLE_W'(dir_vals[k]);
            queue_sample(s, dir_last[k], $urandom_range(0, MAX_IDLE), 1'b0, 1'b0);
        end

        // Random sets. Most are short, a few run longer; each set draws one value
        // distribution so that flat sets (zero deviation), sets pinned near a rail
        // and widely spread sets all show up. Some sets run with no idling at all,
        // and now and then the sender waits for the block to empty first.
        items_made = 0;
        while (items_made < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                len = $urandom_range(1, 4);
            else if (pick < 8)
                len = $urandom_range(5, 16);
            else
                len = $urandom_range(17, 60);
            spread = spread_t'($urandom_range(SPREAD_FULL, SPREAD_NEAR));
            base   = int'($urandom_range(0, 65535)) - 32768;
            calm   = ($urandom_range(0, 4) == 0);
            drain  = ($urandom_range(0, 11) == 0);
            for (k = 0; k < len; k++)
                queue_sample(pick_sample(spread, base), k == len - 1,
                             calm ? 0 : $urandom_range(0, MAX_IDLE), drain && k == 0, calm);
            items_made += len;
        end

        // Two short sets at the end; the first waits until every earlier result
        // has come back.
        for (k = 0; k < 6; k++)
            queue_sample(pick_sample(SPREAD_FULL, 0), k == 2 || k == 5,
                         $urandom_range(0, MAX_IDLE), k == 0, 1'b0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_samples.size() != 0 || tx_valid)
            @(posedge clk);
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Sent %0d samples; checked %0d sets, %0d of them saturated.",
                 samples_sent, sets_checked, sets_overflow);
        $display("Sets covered single samples, both rails, flat and spread data, fractions.");
        if (errors == 0)
            $display("running_mean_stddev_core: match");
        else
            $display("running_mean_stddev_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rms_pkg.sv
sv/rms_in_if.sv
sv/rms_out_if.sv
sv/rms_front.sv
sv/rms_queue.sv
sv/rms_div.sv
sv/rms_back.sv
sv/running_mean_stddev_core.sv
sv/rms_checker.sv
tb/tb_running_mean_stddev_core.sv
